/* src/i2crbm_pkg.sv */
// types and constants shared by the i2c register burst master
`timescale 1ns / 1ps

package i2crbm_pkg;

  localparam int COUNT_WIDTH = 16;

  // input item kinds carried on in_tuser
  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_TICK = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_START      = 4'd1,
    PH_TX_ADDR_W  = 4'd2,
    PH_ACK_ADDR_W = 4'd3,
    PH_TX_REG     = 4'd4,
    PH_ACK_REG    = 4'd5,
    PH_RESTART    = 4'd6,
    PH_TX_ADDR_R  = 4'd7,
    PH_ACK_ADDR_R = 4'd8,
    PH_RX         = 4'd9,
    PH_MACK       = 4'd10,
    PH_WAIT_DATA  = 4'd11,
    PH_TX_DATA    = 4'd12,
    PH_ACK_DATA   = 4'd13,
    PH_STOP       = 4'd14
  } phase_t;

  typedef struct packed {
    logic       failed;
    logic       done_res;
    logic       read_valid;
    logic [7:0] read_value;
    logic       need_byte;
    logic       sda_level;
    logic       scl_level;
  } result_t;

endpackage

/* src/i2c_register_burst_master_top.sv */
// i2c register burst master: bus sequencer with a two-entry result buffer
// an accepted request's result is registered into the output register, or into the skid entry if that is full
// throughput: one request per cycle; the sequencer state updates in one pass
// in_tready drops only when both result registers are full
// reset: synchronous active-low rst_n; bus idle with both lines released high
`timescale 1ns / 1ps

module i2c_register_burst_master_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // device_address[6:0], register_address[14:7], is_read[15], byte_count[31:16],
  // data_byte[39:32], sda_sample[40], zero[47:41]
  input  logic [47:0] in_tdata,
  // kind[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // scl_level[0], sda_level[1], need_byte[2], read_value[10:3], failed[11],
  // zero[15:12]
  output logic [15:0] out_tdata,
  // read_valid[0]
  output logic        out_tuser,
  // done_res
  output logic        out_tlast
);

  localparam int CW = i2crbm_pkg::COUNT_WIDTH;

  logic [6:0]  in_dev;
  logic [7:0]  in_reg;
  logic        in_is_read;
  logic [15:0] in_count;
  logic [7:0]  in_data;
  logic        in_sda;

  assign in_dev     = in_tdata[6:0];
  assign in_reg     = in_tdata[14:7];
  assign in_is_read = in_tdata[15];
  assign in_count   = in_tdata[31:16];
  assign in_data    = in_tdata[39:32];
  assign in_sda     = in_tdata[40];

  i2crbm_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [1:0]    slot_r, slot_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic [CW-1:0] bytes_r, bytes_nxt;
  logic [6:0]    addr_r, addr_nxt;
  logic [7:0]    regi_r, regi_nxt;
  logic          rmode_r, rmode_nxt;
  logic [1:0]    bus_r, bus_nxt;   // {scl, sda}
  logic          nack_r, nack_nxt;

  i2crbm_pkg::result_t res;
  i2crbm_pkg::result_t out_r, skid_r;
  logic out_v_r, skid_v_r;

  logic in_fire, out_fire;

  assign in_tready = !skid_v_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  always_comb begin
    logic          tx_bit;
    logic          step_done;
    logic [CW-1:0] dec;
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    slot_nxt  = slot_r;
    shift_nxt = shift_r;
    bytes_nxt = bytes_r;
    addr_nxt  = addr_r;
    regi_nxt  = regi_r;
    rmode_nxt = rmode_r;
    bus_nxt   = bus_r;
    nack_nxt  = nack_r;
    res            = '0;
    res.scl_level  = bus_r[1];
    res.sda_level  = bus_r[0];
    tx_bit    = shift_r[7];
    step_done = 1'b0;
    dec       = bytes_r - CW'(1);

    case (i2crbm_pkg::kind_t'(in_tuser))
      i2crbm_pkg::KIND_CMD: begin
        if (phase_r == i2crbm_pkg::PH_IDLE) begin
          addr_nxt  = in_dev;
          regi_nxt  = in_reg;
          rmode_nxt = in_is_read;
          bytes_nxt = CW'(in_count);
          nack_nxt  = 1'b0;
          phase_nxt = i2crbm_pkg::PH_START;
          shift_nxt = '0;
          bit_nxt   = '0;
          slot_nxt  = '0;
        end
      end
      i2crbm_pkg::KIND_DATA: begin
        if (phase_r == i2crbm_pkg::PH_WAIT_DATA) begin
          phase_nxt = i2crbm_pkg::PH_TX_DATA;
          shift_nxt = in_data;
          bit_nxt   = '0;
          slot_nxt  = '0;
        end
      end
      i2crbm_pkg::KIND_TICK: begin
        case (phase_r)
          i2crbm_pkg::PH_START, i2crbm_pkg::PH_RESTART: begin
            if (slot_r == 2'd0) begin
              res.scl_level = 1'b1;
              res.sda_level = 1'b1;
              slot_nxt = 2'd1;
            end else begin
              res.scl_level = 1'b1;
              res.sda_level = 1'b0;
              bus_nxt  = 2'b00;
              bit_nxt  = '0;
              slot_nxt = '0;
              if (phase_r == i2crbm_pkg::PH_START) begin
                phase_nxt = i2crbm_pkg::PH_TX_ADDR_W;
                shift_nxt = {addr_r, 1'b0};
              end else begin
                phase_nxt = i2crbm_pkg::PH_TX_ADDR_R;
                shift_nxt = {addr_r, 1'b1};
              end
            end
          end
          i2crbm_pkg::PH_TX_ADDR_W, i2crbm_pkg::PH_TX_REG,
          i2crbm_pkg::PH_TX_ADDR_R, i2crbm_pkg::PH_TX_DATA: begin
            res.sda_level = tx_bit;
            case (slot_r)
              2'd0: begin
                res.scl_level = 1'b0;
                slot_nxt = 2'd1;
              end
              2'd1: begin
                res.scl_level = 1'b1;
                slot_nxt = 2'd2;
              end
              default: begin
                res.scl_level = 1'b0;
                bus_nxt   = {1'b0, tx_bit};
                slot_nxt  = '0;
                shift_nxt = {shift_r[6:0], 1'b0};
                if (bit_r == 3'd7) begin
                  // release sda for the ack slot
                  bus_nxt   = 2'b01;
                  step_done = 1'b1;
                end else begin
                  bit_nxt = bit_r + 3'd1;
                end
              end
            endcase
            if (step_done) begin
              shift_nxt = '0;
              bit_nxt   = '0;
              slot_nxt  = '0;
              case (phase_r)
                i2crbm_pkg::PH_TX_ADDR_W: phase_nxt = i2crbm_pkg::PH_ACK_ADDR_W;
                i2crbm_pkg::PH_TX_REG:    phase_nxt = i2crbm_pkg::PH_ACK_REG;
                i2crbm_pkg::PH_TX_ADDR_R: phase_nxt = i2crbm_pkg::PH_ACK_ADDR_R;
                default:                  phase_nxt = i2crbm_pkg::PH_ACK_DATA;
              endcase
            end
          end
          i2crbm_pkg::PH_ACK_ADDR_W, i2crbm_pkg::PH_ACK_REG,
          i2crbm_pkg::PH_ACK_ADDR_R, i2crbm_pkg::PH_ACK_DATA: begin
            res.sda_level = 1'b1;
            case (slot_r)
              2'd0: begin
                res.scl_level = 1'b0;
                slot_nxt = 2'd1;
              end
              2'd1: begin
                res.scl_level = 1'b1;
                nack_nxt = nack_r | in_sda;
                slot_nxt = 2'd2;
              end
              default: begin
                res.scl_level = 1'b0;
                bus_nxt   = 2'b01;
                step_done = 1'b1;
              end
            endcase
            if (step_done) begin
              shift_nxt = '0;
              bit_nxt   = '0;
              slot_nxt  = '0;
              if (nack_r) begin
                phase_nxt = i2crbm_pkg::PH_STOP;
              end else begin
                case (phase_r)
                  i2crbm_pkg::PH_ACK_ADDR_W: begin
                    phase_nxt = i2crbm_pkg::PH_TX_REG;
                    shift_nxt = regi_r;
                  end
                  i2crbm_pkg::PH_ACK_REG: begin
                    if (rmode_r)
                      phase_nxt = i2crbm_pkg::PH_RESTART;
                    else if (bytes_r == '0)
                      phase_nxt = i2crbm_pkg::PH_STOP;
                    else
                      phase_nxt = i2crbm_pkg::PH_WAIT_DATA;
                  end
                  i2crbm_pkg::PH_ACK_ADDR_R: begin
                    if (bytes_r == '0)
                      phase_nxt = i2crbm_pkg::PH_STOP;
                    else
                      phase_nxt = i2crbm_pkg::PH_RX;
                  end
                  default: begin
                    bytes_nxt = dec;
                    if (dec == '0)
                      phase_nxt = i2crbm_pkg::PH_STOP;
                    else
                      phase_nxt = i2crbm_pkg::PH_WAIT_DATA;
                  end
                endcase
              end
            end
          end
          i2crbm_pkg::PH_RX: begin
            res.sda_level = 1'b1;
            if (slot_r == 2'd0) begin
              res.scl_level = 1'b1;
              shift_nxt = {shift_r[6:0], in_sda};
              slot_nxt  = 2'd1;
            end else begin
              res.scl_level = 1'b0;
              bus_nxt  = 2'b01;
              slot_nxt = '0;
              if (bit_r == 3'd7) begin
                res.read_value = shift_r;
                res.read_valid = 1'b1;
                phase_nxt = i2crbm_pkg::PH_MACK;
                bit_nxt   = '0;
              end else begin
                bit_nxt = bit_r + 3'd1;
              end
            end
          end
          i2crbm_pkg::PH_MACK: begin
            // nack on the last byte, ack otherwise
            res.sda_level = (bytes_r == CW'(1));
            case (slot_r)
              2'd0: begin
                res.scl_level = 1'b0;
                slot_nxt = 2'd1;
              end
              2'd1: begin
                res.scl_level = 1'b1;
                slot_nxt = 2'd2;
              end
              default: begin
                res.scl_level = 1'b0;
                bus_nxt   = 2'b01;
                bytes_nxt = dec;
                shift_nxt = '0;
                bit_nxt   = '0;
                slot_nxt  = '0;
                if (dec == '0)
                  phase_nxt = i2crbm_pkg::PH_STOP;
                else
                  phase_nxt = i2crbm_pkg::PH_RX;
              end
            endcase
          end
          i2crbm_pkg::PH_STOP: begin
            res.scl_level = 1'b1;
            if (slot_r == 2'd0) begin
              res.sda_level = 1'b0;
              bus_nxt  = 2'b10;
              slot_nxt = 2'd1;
            end else begin
              res.sda_level = 1'b1;
              bus_nxt      = 2'b11;
              res.done_res = 1'b1;
              res.failed   = nack_r;
              nack_nxt     = 1'b0;
              phase_nxt    = i2crbm_pkg::PH_IDLE;
              shift_nxt    = '0;
              bit_nxt      = '0;
              slot_nxt     = '0;
            end
          end
          default: begin
            // idle or waiting for data: the bus holds its levels
          end
        endcase
      end
      default: begin
      end
    endcase

    res.need_byte = (phase_nxt == i2crbm_pkg::PH_WAIT_DATA);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= i2crbm_pkg::PH_IDLE;
      bit_r   <= '0;
      slot_r  <= '0;
      shift_r <= '0;
      bytes_r <= '0;
      addr_r  <= '0;
      regi_r  <= '0;
      rmode_r <= 1'b0;
      bus_r   <= 2'b11;
      nack_r  <= 1'b0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      slot_r  <= slot_nxt;
      shift_r <= shift_nxt;
      bytes_r <= bytes_nxt;
      addr_r  <= addr_nxt;
      regi_r  <= regi_nxt;
      rmode_r <= rmode_nxt;
      bus_r   <= bus_nxt;
      nack_r  <= nack_nxt;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_fire) begin
      if (skid_v_r) begin
        skid_v_r <= in_fire;
      end else begin
        out_v_r <= in_fire;
      end
    end else if (in_fire) begin
      if (!out_v_r) out_v_r <= 1'b1;
      else skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      if (skid_v_r) begin
        out_r <= skid_r;
        if (in_fire) skid_r <= res;
      end else if (in_fire) begin
        out_r <= res;
      end
    end else if (in_fire) begin
      if (!out_v_r) out_r <= res;
      else skid_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0000, out_r.failed, out_r.read_value, out_r.need_byte,
                       out_r.sda_level, out_r.scl_level};
  assign out_tuser  = out_r.read_valid;
  assign out_tlast  = out_r.done_res;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry full while output register empty");

  a_idle_bus_released: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == i2crbm_pkg::PH_IDLE |-> bus_r == 2'b11)
    else $error("bus not released while idle");

  a_wait_scl_low: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == i2crbm_pkg::PH_WAIT_DATA |-> bus_r == 2'b01)
    else $error("waiting for data without scl low and sda released");

  a_rx_byte_then_mack: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res.read_valid |=> phase_r == i2crbm_pkg::PH_MACK)
    else $error("received byte not followed by master ack");

  a_rx_two_slots: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == i2crbm_pkg::PH_RX |-> slot_r <= 2'd1)
    else $error("receive bit beyond two slots");
`endif

endmodule

/* sim/i2c_register_burst_master_top_tb.sv */
// testbench for the i2c register burst master: bus sequences checked slot by slot
`timescale 1ns / 1ps

module i2c_register_burst_master_top_tb;

  localparam int          CLK_HALF     = 10;
  localparam int          LIMIT_CYCLES = 600000;
  localparam int          LONG_HOLD    = 150;
  localparam int          ITEM_TARGET  = 1650;
  localparam int          MAX_REPORTS  = 10;
  localparam int          NO_NACK      = -1;
  localparam int          ANY_BYTE     = -1;
  localparam int          CW           = i2crbm_pkg::COUNT_WIDTH;
  // kind value the block has no meaning for
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;

  // tracks the bus sequencer and holds the line levels each request should produce
  class burst_scoreboard;
    i2crbm_pkg::phase_t     phase;
    logic [2:0]             bit_idx;
    logic [1:0]             slot;
    logic [7:0]             shreg;
    logic [CW-1:0]          remaining;
    logic [6:0]             dev;
    logic [7:0]             regaddr;
    logic                   rd;
    logic                   scl_hold;
    logic                   sda_hold;
    logic                   nack;
    i2crbm_pkg::result_t    r;
    i2crbm_pkg::result_t    levels_q[$];
    int                     errors;
    int                     checked;
    int                     bytes_read;
    int                     bytes_written;
    int                     transfers_done;
    int                     transfers_failed;

    function void clear();
      phase            = i2crbm_pkg::PH_IDLE;
      bit_idx          = '0;
      slot             = '0;
      shreg            = '0;
      remaining        = '0;
      dev              = '0;
      regaddr          = '0;
      rd               = 1'b0;
      scl_hold         = 1'b1;
      sda_hold         = 1'b1;
      nack             = 1'b0;
      errors           = 0;
      checked          = 0;
      bytes_read       = 0;
      bytes_written    = 0;
      transfers_done   = 0;
      transfers_failed = 0;
      levels_q.delete();
    endfunction

    function int pending();
      return levels_q.size();
    endfunction

    // the tick about to be sent lands on the sda sample of an ack check
    function bit ack_sampling();
      return slot == 2'd1 && (phase == i2crbm_pkg::PH_ACK_ADDR_W ||
                              phase == i2crbm_pkg::PH_ACK_REG ||
                              phase == i2crbm_pkg::PH_ACK_ADDR_R ||
                              phase == i2crbm_pkg::PH_ACK_DATA);
    endfunction

    function void go(i2crbm_pkg::phase_t p, logic [7:0] s);
      phase   = p;
      shreg   = s;
      bit_idx = '0;
      slot    = '0;
    endfunction

    function void drive(logic c, logic d);
      r.scl_level = c;
      r.sda_level = d;
    endfunction

    function void park(logic c, logic d);
      scl_hold = c;
      sda_hold = d;
    endfunction

    function bit shift_out_slot();
      logic b;
      b = shreg[7];
      if (slot == 2'd0) begin
        drive(1'b0, b);
        slot = 2'd1;
        return 1'b0;
      end
      if (slot == 2'd1) begin
        drive(1'b1, b);
        slot = 2'd2;
        return 1'b0;
      end
      drive(1'b0, b);
      park(1'b0, b);
      slot  = 2'd0;
      shreg = {shreg[6:0], 1'b0};
      if (bit_idx == 3'd7) begin
        park(1'b0, 1'b1);
        bit_idx = '0;
        return 1'b1;
      end
      bit_idx++;
      return 1'b0;
    endfunction

    function bit ack_check_slot(logic sda);
      if (slot == 2'd0) begin
        drive(1'b0, 1'b1);
        slot = 2'd1;
        return 1'b0;
      end
      if (slot == 2'd1) begin
        drive(1'b1, 1'b1);
        if (sda) nack = 1'b1;
        slot = 2'd2;
        return 1'b0;
      end
      drive(1'b0, 1'b1);
      park(1'b0, 1'b1);
      slot = 2'd0;
      return 1'b1;
    endfunction

    function void bus_slot(logic sda);
      logic a;
      case (phase)
        i2crbm_pkg::PH_START, i2crbm_pkg::PH_RESTART: begin
          if (slot == 2'd0) begin
            drive(1'b1, 1'b1);
            slot = 2'd1;
          end else begin
            drive(1'b1, 1'b0);
            park(1'b0, 1'b0);
            if (phase == i2crbm_pkg::PH_START) go(i2crbm_pkg::PH_TX_ADDR_W, {dev, 1'b0});
            else go(i2crbm_pkg::PH_TX_ADDR_R, {dev, 1'b1});
          end
        end
        i2crbm_pkg::PH_TX_ADDR_W:
          if (shift_out_slot()) go(i2crbm_pkg::PH_ACK_ADDR_W, 8'h00);
        i2crbm_pkg::PH_TX_REG:
          if (shift_out_slot()) go(i2crbm_pkg::PH_ACK_REG, 8'h00);
        i2crbm_pkg::PH_TX_ADDR_R:
          if (shift_out_slot()) go(i2crbm_pkg::PH_ACK_ADDR_R, 8'h00);
        i2crbm_pkg::PH_TX_DATA:
          if (shift_out_slot()) go(i2crbm_pkg::PH_ACK_DATA, 8'h00);
        i2crbm_pkg::PH_ACK_ADDR_W, i2crbm_pkg::PH_ACK_REG,
        i2crbm_pkg::PH_ACK_ADDR_R, i2crbm_pkg::PH_ACK_DATA: begin
          if (ack_check_slot(sda)) begin
            if (nack) begin
              go(i2crbm_pkg::PH_STOP, 8'h00);
            end else if (phase == i2crbm_pkg::PH_ACK_ADDR_W) begin
              go(i2crbm_pkg::PH_TX_REG, regaddr);
            end else if (phase == i2crbm_pkg::PH_ACK_REG) begin
              if (rd) go(i2crbm_pkg::PH_RESTART, 8'h00);
              else if (remaining == '0) go(i2crbm_pkg::PH_STOP, 8'h00);
              else go(i2crbm_pkg::PH_WAIT_DATA, 8'h00);
            end else if (phase == i2crbm_pkg::PH_ACK_ADDR_R) begin
              if (remaining == '0) go(i2crbm_pkg::PH_STOP, 8'h00);
              else go(i2crbm_pkg::PH_RX, 8'h00);
            end else begin
              remaining = remaining - CW'(1);
              if (remaining == '0) go(i2crbm_pkg::PH_STOP, 8'h00);
              else go(i2crbm_pkg::PH_WAIT_DATA, 8'h00);
            end
          end
        end
        i2crbm_pkg::PH_RX: begin
          if (slot == 2'd0) begin
            drive(1'b1, 1'b1);
            shreg = {shreg[6:0], sda};
            slot  = 2'd1;
          end else begin
            drive(1'b0, 1'b1);
            park(1'b0, 1'b1);
            slot = 2'd0;
            if (bit_idx == 3'd7) begin
              r.read_value = shreg;
              r.read_valid = 1'b1;
              bytes_read++;
              go(i2crbm_pkg::PH_MACK, shreg);
            end else begin
              bit_idx++;
            end
          end
        end
        i2crbm_pkg::PH_MACK: begin
          // nack from the master only after the final byte
          a = (remaining == CW'(1)) ? 1'b1 : 1'b0;
          if (slot == 2'd0) begin
            drive(1'b0, a);
            slot = 2'd1;
          end else if (slot == 2'd1) begin
            drive(1'b1, a);
            slot = 2'd2;
          end else begin
            drive(1'b0, a);
            park(1'b0, 1'b1);
            remaining = remaining - CW'(1);
            if (remaining == '0) go(i2crbm_pkg::PH_STOP, 8'h00);
            else go(i2crbm_pkg::PH_RX, 8'h00);
          end
        end
        i2crbm_pkg::PH_STOP: begin
          if (slot == 2'd0) begin
            drive(1'b1, 1'b0);
            park(1'b1, 1'b0);
            slot = 2'd1;
          end else begin
            drive(1'b1, 1'b1);
            park(1'b1, 1'b1);
            r.done_res = 1'b1;
            r.failed   = nack;
            transfers_done++;
            if (nack) transfers_failed++;
            nack = 1'b0;
            go(i2crbm_pkg::PH_IDLE, 8'h00);
          end
        end
        default: ;
      endcase
    endfunction

    function void note_request(logic [1:0] kind, logic [47:0] d);
      r           = '0;
      r.scl_level = scl_hold;
      r.sda_level = sda_hold;
      if (kind == i2crbm_pkg::KIND_CMD) begin
        if (phase == i2crbm_pkg::PH_IDLE) begin
          dev       = d[6:0];
          regaddr   = d[14:7];
          rd        = d[15];
          remaining = CW'(d[31:16]);
          nack      = 1'b0;
          go(i2crbm_pkg::PH_START, 8'h00);
        end
      end else if (kind == i2crbm_pkg::KIND_DATA) begin
        if (phase == i2crbm_pkg::PH_WAIT_DATA) begin
          bytes_written++;
          go(i2crbm_pkg::PH_TX_DATA, d[39:32]);
        end
      end else if (kind == i2crbm_pkg::KIND_TICK) begin
        bus_slot(d[40]);
      end
      r.need_byte = (phase == i2crbm_pkg::PH_WAIT_DATA);
      levels_q.push_back(r);
    endfunction

    function void check_result(logic [15:0] td, logic tu, logic tl);
      i2crbm_pkg::result_t e;
      i2crbm_pkg::result_t a;
      a            = '0;
      a.scl_level  = td[0];
      a.sda_level  = td[1];
      a.need_byte  = td[2];
      a.read_value = td[10:3];
      a.failed     = td[11];
      a.read_valid = tu;
      a.done_res   = tl;
      checked++;
      if (levels_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result %0d arrived with nothing outstanding", $realtime, checked);
        return;
      end
      e = levels_q.pop_front();
      if (a.scl_level !== e.scl_level || a.sda_level !== e.sda_level ||
          a.need_byte !== e.need_byte || a.read_value !== e.read_value ||
          a.read_valid !== e.read_valid || a.done_res !== e.done_res ||
          a.failed !== e.failed) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: result %0d mismatch", $realtime, checked);
          $display("  exp scl %b sda %b need %b rval %h rvalid %b done %b failed %b",
                   e.scl_level, e.sda_level, e.need_byte, e.read_value, e.read_valid,
                   e.done_res, e.failed);
          $display("  got scl %b sda %b need %b rval %h rvalid %b done %b failed %b",
                   a.scl_level, a.sda_level, a.need_byte, a.read_value, a.read_valid,
                   a.done_res, a.failed);
        end
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = i2crbm_pkg::KIND_CMD;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  burst_scoreboard sb;
  int  cycles       = 0;
  int  requests     = 0;
  int  counted      = 0;
  int  transfers    = 0;
  bit  tx_steady    = 1'b0;
  bit  rx_steady    = 1'b0;
  bit  hold_request = 1'b0;

  i2c_register_burst_master_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
    $display("i2c_register_burst_master_top_tb: done, errors");
    $finish;
  end

  // fields a request does not use carry random bits
  function automatic logic [47:0] pack_item(logic [6:0] dev, logic [7:0] ra, logic rd,
                                            logic [15:0] cnt, logic [7:0] dbyte,
                                            logic sda);
    return {7'b0, sda, dbyte, cnt, rd, ra, dev};
  endfunction

  function automatic logic [47:0] noise_item();
    return pack_item(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endfunction

  task automatic send(input logic [1:0] kind, input logic [47:0] d);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : int'($urandom_range(0, 17));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(kind, d);
    requests++;
  endtask

  // requests the sequencer should ignore in its current phase
  task automatic send_noise();
    int pick;
    pick = int'($urandom_range(0, 2));
    if (pick == 0) send(KIND_UNUSED, noise_item());
    else if (pick == 1 && sb.phase != i2crbm_pkg::PH_IDLE)
      send(i2crbm_pkg::KIND_CMD, noise_item());
    else if (sb.phase != i2crbm_pkg::PH_WAIT_DATA) send(i2crbm_pkg::KIND_DATA, noise_item());
    else send(i2crbm_pkg::KIND_TICK, noise_item());
  endtask

  // one command and the ticks and data bytes it needs; the slave nacks at ack number nack_at
  task automatic run_transfer(input logic [6:0] dev, input logic [7:0] ra, input logic rd,
                              input logic [15:0] cnt, input int nack_at,
                              input int fixed_byte);
    int          ack_no;
    logic [47:0] d;
    ack_no = 0;
    d = noise_item();
    d[31:0] = {cnt, rd, ra, dev};
    send(i2crbm_pkg::KIND_CMD, d);
    counted++;
    while (sb.phase != i2crbm_pkg::PH_IDLE) begin
      d = noise_item();
      if ($urandom_range(0, 59) == 0) begin
        send_noise();
      end else if (sb.phase == i2crbm_pkg::PH_WAIT_DATA) begin
        if (fixed_byte != ANY_BYTE) d[39:32] = fixed_byte[7:0];
        send(i2crbm_pkg::KIND_DATA, d);
        counted++;
      end else begin
        if (sb.ack_sampling()) begin
          d[40] = (ack_no == nack_at);
          ack_no++;
        end
        send(i2crbm_pkg::KIND_TICK, d);
        counted++;
      end
    end
    transfers++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
        stall = rx_steady ? 0 : int'($urandom_range(0, 17));
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_result(out_tdata, out_tuser, out_tlast);
    end
  end

  initial begin
    logic [15:0] cnt;
    logic        rd;
    int          nack_at;
    int          leftover;
    sb = new();
    sb.clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ignored requests on an idle bus
    send(i2crbm_pkg::KIND_TICK, pack_item(7'h7f, 8'hff, 1'b1, 16'hffff, 8'hff, 1'b1));
    send(i2crbm_pkg::KIND_TICK, pack_item(7'h00, 8'h00, 1'b0, 16'h0000, 8'h00, 1'b0));
    send(i2crbm_pkg::KIND_DATA, pack_item(7'h00, 8'h00, 1'b0, 16'h0000, 8'hff, 1'b0));
    send(KIND_UNUSED, pack_item(7'h7f, 8'hff, 1'b1, 16'hffff, 8'hff, 1'b1));

    // zero-length bursts, data bytes of both extremes, every ack point refused
    run_transfer(7'h00, 8'h00, 1'b0, 16'd0, NO_NACK, ANY_BYTE);
    run_transfer(7'h7f, 8'hff, 1'b1, 16'd0, NO_NACK, ANY_BYTE);
    run_transfer(7'h2a, 8'h55, 1'b0, 16'd1, NO_NACK, 8'hff);
    run_transfer(7'h55, 8'haa, 1'b0, 16'd2, NO_NACK, 8'h00);
    run_transfer(7'h7f, 8'h00, 1'b1, 16'd2, NO_NACK, ANY_BYTE);
    run_transfer(7'h00, 8'hff, 1'b0, 16'hffff, 0, ANY_BYTE);
    run_transfer(7'h7f, 8'hff, 1'b1, 16'hffff, 2, ANY_BYTE);
    run_transfer(7'h11, 8'h22, 1'b1, 16'd3, 1, ANY_BYTE);
    run_transfer(7'h33, 8'h44, 1'b0, 16'd3, 3, ANY_BYTE);

    while (counted < ITEM_TARGET) begin
      rd = 1'($urandom_range(0, 1));
      nack_at = NO_NACK;
      if ($urandom_range(0, 3) == 0) begin
        // long bursts are cut short by a refused ack
        cnt = 16'($urandom_range(0, 65535));
        nack_at = rd ? int'($urandom_range(0, 2)) : int'($urandom_range(0, 5));
      end else begin
        cnt = 16'($urandom_range(0, 3));
        if ($urandom_range(0, 6) == 0) nack_at = int'($urandom_range(0, 3 + int'(cnt)));
      end
      if (transfers == 12) hold_request = 1'b1;
      if (transfers == 16) drain();
      if ($urandom_range(0, 4) == 0) send_noise();
      run_transfer(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), rd, cnt,
                   nack_at, ANY_BYTE);
    end

    drain();
    repeat (5) @(posedge clk);
    leftover = sb.pending();
    $display("ran %0d transfers (%0d refused by the slave) over %0d requests",
             sb.transfers_done, sb.transfers_failed, requests);
    $display("%0d bytes written, %0d bytes read, %0d results checked",
             sb.bytes_written, sb.bytes_read, sb.checked);
    if (sb.errors == 0 && leftover == 0) begin
      $display("i2c_register_burst_master_top_tb: done, clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.errors, leftover);
      $display("i2c_register_burst_master_top_tb: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
src/i2crbm_pkg.sv
src/i2c_register_burst_master_top.sv
sim/i2c_register_burst_master_top_tb.sv
